### rtl/ltfp_pkg.sv
package ltfp_pkg;

  localparam int unsigned HDR_BYTES   = 6;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_LEN_ERR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_TYPE = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] frame_length;
    logic [15:0] type_code;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

endpackage

### rtl/ltfp_parser.sv
module ltfp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                queue_full,
  output logic                push,
  output ltfp_pkg::result_t   push_data
);
  import ltfp_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  cnt, cnt_next;
  logic [31:0] length_reg, length_reg_next;
  logic [15:0] type_reg, type_reg_next;
  logic [31:0] remaining, remaining_next;
  logic        has_result;
  logic        accept;
  logic [31:0] len_asm;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEN;
      cnt        <= 2'd0;
      length_reg <= 32'd0;
      type_reg   <= 16'd0;
      remaining  <= 32'd0;
    end else if (accept) begin
      phase      <= phase_next;
      cnt        <= cnt_next;
      length_reg <= length_reg_next;
      type_reg   <= type_reg_next;
      remaining  <= remaining_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    cnt_next        = cnt;
    length_reg_next = length_reg;
    type_reg_next   = type_reg;
    remaining_next  = remaining;
    has_result      = 1'b0;
    push_data       = '0;
    len_asm         = 32'd0;

    case (phase)
      PH_TYPE: begin
        if (cnt == 2'd0) begin
          type_reg_next = {type_reg[15:8], data_byte};
        end else if (cnt == 2'd1) begin
          type_reg_next = {data_byte, type_reg[7:0]};
        end
        if (cnt == 2'd0) begin
          cnt_next = 2'd1;
        end else begin
          cnt_next                = 2'd0;
          has_result              = 1'b1;
          push_data.kind          = KIND_HEADER;
          push_data.frame_length  = length_reg;
          push_data.type_code     = type_reg_next;
          if (length_reg == 32'(HDR_BYTES)) begin
            phase_next     = PH_LEN;
            remaining_next = 32'd0;
            push_data.last = 1'b1;
          end else begin
            phase_next     = PH_BODY;
            remaining_next = length_reg - 32'(HDR_BYTES);
          end
        end
      end

      PH_BODY: begin
        has_result             = 1'b1;
        push_data.kind         = KIND_PAYLOAD;
        push_data.frame_length = length_reg;
        push_data.type_code    = type_reg;
        push_data.payload_byte = data_byte;
        push_data.last         = (remaining <= 32'd1);
        if (remaining <= 32'd1) begin
          remaining_next = 32'd0;
          phase_next     = PH_LEN;
          cnt_next       = 2'd0;
        end else begin
          remaining_next = remaining - 32'd1;
        end
      end

      default: begin
        // length field, little-endian; an unused phase code reads as this one
        phase_next = PH_LEN;
        len_asm    = (cnt == 2'd0) ? 32'd0 : length_reg;
        case (cnt)
          2'd0:    len_asm[7:0]   = data_byte;
          2'd1:    len_asm[15:8]  = len_asm[15:8] | data_byte;
          2'd2:    len_asm[23:16] = len_asm[23:16] | data_byte;
          default: len_asm[31:24] = len_asm[31:24] | data_byte;
        endcase
        length_reg_next = len_asm;
        if (cnt != 2'd3) begin
          cnt_next = cnt + 2'd1;
        end else begin
          cnt_next      = 2'd0;
          type_reg_next = 16'd0;
          if (len_asm < 32'(HDR_BYTES)) begin
            has_result             = 1'b1;
            push_data.kind         = KIND_LEN_ERR;
            push_data.frame_length = len_asm;
            push_data.last         = 1'b1;
          end else begin
            phase_next = PH_TYPE;
          end
        end
      end
    endcase
  end

endmodule

### rtl/ltfp_queue.sv
module ltfp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ltfp_pkg::result_t   push_data,
  input  logic                pop,
  output ltfp_pkg::result_t   head,
  output logic                full,
  output logic                empty
);
  import ltfp_pkg::*;

  result_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/ltfp_emit.sv
module ltfp_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                queue_empty,
  input  ltfp_pkg::result_t   head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output ltfp_pkg::result_t   out_data
);
  import ltfp_pkg::*;

  // refill the output register when it is empty or its transfer completes
  assign pop = !queue_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= head;
    end
  end

endmodule

### rtl/length_type_frame_parser.sv
// Length/type framed byte stream parser.
// Input channel: one raw byte per transfer on data_byte (in_valid/in_ready).
// Each frame is a 4-byte little-endian total length, a 2-byte little-endian
// type code and (length - 6) payload bytes.
// Output channel (out_valid/out_ready): one header result (kind 0) when the
// type code completes, one result per payload byte (kind 1), and an error
// result (kind 2) for a length below 6. last marks the final result of a
// frame; a header with an empty payload and an error both carry last.
// Throughput: one byte per clock while the result queue is not full.
// Results pass through registers: the parse step writes a 4-entry result
// queue at the transfer edge, and the output register loads from the queue
// when it is empty or its current transfer completes.
// Reset: the parser returns to the length field and the queue empties.
// When the receiver stalls, results collect in the queue; in_ready drops
// once the queue is full and rises again as soon as one result leaves.
module length_type_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [31:0] frame_length,
  output logic [15:0] type_code,
  output logic [7:0]  payload_byte,
  output logic        last
);
  import ltfp_pkg::*;

  logic    push;
  logic    pop;
  logic    queue_full;
  logic    queue_empty;
  result_t push_data;
  result_t head;
  result_t out_data;

  ltfp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  ltfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  ltfp_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  assign kind         = out_data.kind;
  assign frame_length = out_data.frame_length;
  assign type_code    = out_data.type_code;
  assign payload_byte = out_data.payload_byte;
  assign last         = out_data.last;

endmodule
